### rtl/core/ffsa_pkg.sv
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants of the first-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffsa_pkg;

  localparam int START_W = 16;
  localparam int SIZE_W  = 17;
  localparam int LIM_W   = 6;

  localparam int DEF_MAX_SEGMENTS   = 32;
  localparam int DEF_MAX_HEAP_BYTES = 65536;

  localparam int HEAP_RST = 65536;
  localparam int LIM_RST  = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  // Configuration register indexes.
  localparam logic CFG_HEAP_BYTES    = 1'b0;
  localparam logic CFG_SEGMENT_LIMIT = 1'b1;

  // Request kinds carried on in_tuser.
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // One segment table entry.
  typedef struct packed {
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [START_W-1:0] start;
  } seg_t;

endpackage

`default_nettype wire

### rtl/core/first_fit_segment_allocator_top.sv
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_top
// First-fit segment allocator with coalescing over a memory-held table.
// ----------------------------------------------------------------------------
// Usage: a request word enters on the in_ channel (in_tuser selects allocate
// or free). The block scans its segment table, which lives in a synchronous
// single-read-port memory, one entry per cycle. An allocate takes the first
// free segment that fits and may split it; a free looks up the start offset
// and merges the segment with free neighbors. Table entries are shifted up
// or down one at a time, each moved entry read and then written back. A
// final pass over the table gathers the free total, the largest free
// segment and the used count. A zero-byte allocate is the quickest request,
// a split of entry 0, which moves every later entry up, the slowest; the
// memory's single read port sets the pace. Only one request is in flight;
// unless a configuration write is pending, in_tready rises in the same cycle
// that the result word appears in the output register, so the next request
// is taken while the result still waits. If the receiver stalls, the result
// word holds and a finished request waits until the output register is free.
// After reset, and after any configuration write once the block is idle,
// the block writes entry 0 of the table (in_tready low) to hold a single
// free segment of heap_bytes bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_segment_allocator_top
  import ffsa_pkg::*;
#(
  parameter int MAX_SEGMENTS   = DEF_MAX_SEGMENTS,
  parameter int MAX_HEAP_BYTES = DEF_MAX_HEAP_BYTES
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration write port.
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [SIZE_W-1:0]      cfg_wdata,
  // Request channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // tdata: request_size[16:0], free_offset[32:17], zero padding above.
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tuser: kind (0 allocate, 1 free).
  input  wire logic                   in_tuser,
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // tdata: ok[0], granted_offset[16:1], free_total[33:17],
  // largest_free[50:34], allocs_left[56:51], zero padding above.
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  localparam int AW    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int CMP_W = ((CNT_W > LIM_W) ? CNT_W : LIM_W) + 1;

  localparam int HEAP_INIT = (HEAP_RST > MAX_HEAP_BYTES) ? MAX_HEAP_BYTES : HEAP_RST;
  localparam int LIM_INIT  = (LIM_RST > MAX_SEGMENTS) ? MAX_SEGMENTS : LIM_RST;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN    = 4'd1;
  localparam logic [3:0] S_SH_RD   = 4'd2;
  localparam logic [3:0] S_SH_WR   = 4'd3;
  localparam logic [3:0] S_SPL_A   = 4'd4;
  localparam logic [3:0] S_SPL_B   = 4'd5;
  localparam logic [3:0] S_FR_PREV = 4'd6;
  localparam logic [3:0] S_FR_NEXT = 4'd7;
  localparam logic [3:0] S_FR_MRG  = 4'd8;
  localparam logic [3:0] S_RM_RD   = 4'd9;
  localparam logic [3:0] S_RM_WR   = 4'd10;
  localparam logic [3:0] S_STAT    = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0]         state_r, state_nxt;
  logic               init_pend_r, init_pend_nxt;
  logic [SIZE_W-1:0]  heap_r, heap_nxt;
  logic [LIM_W-1:0]   lim_r, lim_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               kind_r, kind_nxt;
  logic [SIZE_W-1:0]  want_r, want_nxt;
  logic [START_W-1:0] off_r, off_nxt;
  logic               ok_r, ok_nxt;
  logic [START_W-1:0] gr_r, gr_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic               rv_r, rv_nxt;
  logic [CNT_W-1:0]   ri_r, ri_nxt;
  logic [CNT_W-1:0]   hit_idx_r, hit_idx_nxt;
  seg_t               hit_r, hit_nxt;
  seg_t               prev_r, prev_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [1:0]         rm_n_r, rm_n_nxt;
  logic [SIZE_W-1:0]  tot_r, tot_nxt;
  logic [SIZE_W-1:0]  big_r, big_nxt;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  seg_t            mem_wdata;
  logic [AW-1:0]   mem_raddr;
  seg_t            mem_rdata;

  logic [SIZE_W-1:0] cfg_heap;
  logic [LIM_W-1:0]  cfg_lim;
  logic              match;
  logic              split_ok;
  logic              prev_free;
  logic              next_free;
  logic [CMP_W-1:0]  hit_p1;
  logic [LIM_W-1:0]  allocs_left;

  ffsa_mem #(
    .DEPTH (MAX_SEGMENTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Register writes are clamped into their legal ranges.
  always_comb begin
    cfg_heap = cfg_wdata;
    if (cfg_heap == '0) begin
      cfg_heap = SIZE_W'(1);
    end
    if (32'(cfg_wdata) > 32'(MAX_HEAP_BYTES)) begin
      cfg_heap = SIZE_W'(MAX_HEAP_BYTES);
    end
    cfg_lim = cfg_wdata[LIM_W-1:0];
    if (cfg_lim < LIM_W'(2)) begin
      cfg_lim = LIM_W'(2);
    end
    if (32'(cfg_wdata[LIM_W-1:0]) > 32'(MAX_SEGMENTS)) begin
      cfg_lim = LIM_W'(MAX_SEGMENTS);
    end
  end

  assign hit_p1 = CMP_W'(hit_idx_r) + CMP_W'(1);

  // A hit during the scan: first free segment that fits, or exact start.
  assign match = rv_r && ((kind_r == KIND_FREE) ? (mem_rdata.start == off_r)
                          : (!mem_rdata.used && (mem_rdata.size >= want_r)));

  // The segment is cut only if the table has a spare slot after it and the
  // request leaves a remainder.
  assign split_ok = (CMP_W'(cnt_r) < CMP_W'(lim_r)) &&
                    ((CMP_W'(ri_r) + CMP_W'(1)) < CMP_W'(lim_r)) &&
                    (mem_rdata.size != want_r);

  assign prev_free = (hit_idx_r != '0) && !prev_r.used;
  assign next_free = (hit_p1 < CMP_W'(cnt_r)) && !mem_rdata.used;

  assign allocs_left = lim_r - LIM_W'(used_r);

  always_comb begin
    state_nxt      = state_r;
    init_pend_nxt  = init_pend_r;
    heap_nxt       = heap_r;
    lim_nxt        = lim_r;
    cnt_nxt        = cnt_r;
    kind_nxt       = kind_r;
    want_nxt       = want_r;
    off_nxt        = off_r;
    ok_nxt         = ok_r;
    gr_nxt         = gr_r;
    i_nxt          = i_r;
    rv_nxt         = rv_r;
    ri_nxt         = ri_r;
    hit_idx_nxt    = hit_idx_r;
    hit_nxt        = hit_r;
    prev_nxt       = prev_r;
    j_nxt          = j_r;
    rm_n_nxt       = rm_n_r;
    tot_nxt        = tot_r;
    big_nxt        = big_r;
    used_nxt       = used_r;
    out_tdata_nxt  = out_tdata_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    mem_we         = 1'b0;
    mem_waddr      = '0;
    mem_wdata      = hit_r;
    mem_raddr      = i_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (init_pend_r) begin
          mem_we        = 1'b1;
          mem_waddr     = '0;
          mem_wdata     = '{used: 1'b0, size: heap_r, start: '0};
          cnt_nxt       = CNT_W'(1);
          init_pend_nxt = 1'b0;
        end else if (in_tvalid && in_tready) begin
          kind_nxt = in_tuser;
          want_nxt = in_tdata[SIZE_W-1:0];
          off_nxt  = in_tdata[SIZE_W+START_W-1:SIZE_W];
          ok_nxt   = 1'b0;
          gr_nxt   = '0;
          i_nxt    = '0;
          rv_nxt   = 1'b0;
          tot_nxt  = '0;
          big_nxt  = '0;
          used_nxt = '0;
          if ((in_tuser == KIND_ALLOC) && (in_tdata[SIZE_W-1:0] == '0)) begin
            state_nxt = S_STAT;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (i_r < cnt_r) begin
          i_nxt  = i_r + CNT_W'(1);
          rv_nxt = 1'b1;
          ri_nxt = i_r;
        end else begin
          rv_nxt = 1'b0;
        end
        if (match) begin
          hit_idx_nxt = ri_r;
          hit_nxt     = mem_rdata;
          ok_nxt      = 1'b1;
          i_nxt       = '0;
          rv_nxt      = 1'b0;
          if (kind_r == KIND_FREE) begin
            state_nxt = S_FR_PREV;
          end else begin
            gr_nxt = mem_rdata.start;
            if (split_ok) begin
              j_nxt     = cnt_r;
              state_nxt = S_SH_RD;
            end else begin
              mem_we         = 1'b1;
              mem_waddr      = ri_r[AW-1:0];
              mem_wdata      = mem_rdata;
              mem_wdata.used = 1'b1;
              state_nxt      = S_STAT;
            end
          end
        end else if (!rv_r && (i_r >= cnt_r)) begin
          i_nxt     = '0;
          rv_nxt    = 1'b0;
          state_nxt = S_STAT;
        end
      end

      // Open a slot after the hit by moving later entries up, top first.
      S_SH_RD: begin
        if (CMP_W'(j_r) > hit_p1) begin
          mem_raddr = AW'(j_r - CNT_W'(1));
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_SPL_A;
        end
      end

      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        mem_wdata = mem_rdata;
        j_nxt     = j_r - CNT_W'(1);
        state_nxt = S_SH_RD;
      end

      S_SPL_A: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(hit_p1);
        mem_wdata = '{used:  1'b0,
                      size:  hit_r.size - want_r,
                      start: hit_r.start + want_r[START_W-1:0]};
        state_nxt = S_SPL_B;
      end

      S_SPL_B: begin
        mem_we    = 1'b1;
        mem_waddr = hit_idx_r[AW-1:0];
        mem_wdata = '{used: 1'b1, size: want_r, start: hit_r.start};
        cnt_nxt   = cnt_r + CNT_W'(1);
        state_nxt = S_STAT;
      end

      S_FR_PREV: begin
        mem_raddr = AW'(hit_idx_r - CNT_W'(1));
        state_nxt = S_FR_NEXT;
      end

      S_FR_NEXT: begin
        prev_nxt  = mem_rdata;
        mem_raddr = AW'(hit_p1);
        state_nxt = S_FR_MRG;
      end

      // mem_rdata holds the next entry here.
      S_FR_MRG: begin
        mem_we = 1'b1;
        if (prev_free && next_free) begin
          mem_waddr = AW'(hit_idx_r - CNT_W'(1));
          mem_wdata = '{used: 1'b0, size: prev_r.size + hit_r.size + mem_rdata.size,
                        start: prev_r.start};
          j_nxt     = hit_idx_r;
          rm_n_nxt  = 2'd2;
          state_nxt = S_RM_RD;
        end else if (prev_free) begin
          mem_waddr = AW'(hit_idx_r - CNT_W'(1));
          mem_wdata = '{used: 1'b0, size: prev_r.size + hit_r.size, start: prev_r.start};
          j_nxt     = hit_idx_r;
          rm_n_nxt  = 2'd1;
          state_nxt = S_RM_RD;
        end else if (next_free) begin
          mem_waddr = hit_idx_r[AW-1:0];
          mem_wdata = '{used: 1'b0, size: hit_r.size + mem_rdata.size, start: hit_r.start};
          j_nxt     = CNT_W'(hit_p1);
          rm_n_nxt  = 2'd1;
          state_nxt = S_RM_RD;
        end else begin
          mem_waddr = hit_idx_r[AW-1:0];
          mem_wdata = '{used: 1'b0, size: hit_r.size, start: hit_r.start};
          i_nxt     = '0;
          rv_nxt    = 1'b0;
          state_nxt = S_STAT;
        end
      end

      // Close the gap left by merged entries, lowest entry first.
      S_RM_RD: begin
        if ((CMP_W'(j_r) + CMP_W'(rm_n_r)) < CMP_W'(cnt_r)) begin
          mem_raddr = AW'(j_r + CNT_W'(rm_n_r));
          state_nxt = S_RM_WR;
        end else begin
          cnt_nxt   = cnt_r - CNT_W'(rm_n_r);
          i_nxt     = '0;
          rv_nxt    = 1'b0;
          state_nxt = S_STAT;
        end
      end

      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = j_r[AW-1:0];
        mem_wdata = mem_rdata;
        j_nxt     = j_r + CNT_W'(1);
        state_nxt = S_RM_RD;
      end

      S_STAT: begin
        if (i_r < cnt_r) begin
          i_nxt  = i_r + CNT_W'(1);
          rv_nxt = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          if (mem_rdata.used) begin
            used_nxt = used_r + CNT_W'(1);
          end else begin
            tot_nxt = tot_r + mem_rdata.size;
            if (mem_rdata.size > big_r) begin
              big_nxt = mem_rdata.size;
            end
          end
        end else if (i_r >= cnt_r) begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {7'b0, allocs_left, big_r, tot_r, gr_r, ok_r};
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      init_pend_nxt = 1'b1;
      if (cfg_index == CFG_HEAP_BYTES) begin
        heap_nxt = cfg_heap;
      end else begin
        lim_nxt = cfg_lim;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      init_pend_r  <= 1'b1;
      heap_r       <= SIZE_W'(HEAP_INIT);
      lim_r        <= LIM_W'(LIM_INIT);
      cnt_r        <= CNT_W'(1);
      i_r          <= '0;
      rv_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_pend_r  <= init_pend_nxt;
      heap_r       <= heap_nxt;
      lim_r        <= lim_nxt;
      cnt_r        <= cnt_nxt;
      i_r          <= i_nxt;
      rv_r         <= rv_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    want_r      <= want_nxt;
    off_r       <= off_nxt;
    ok_r        <= ok_nxt;
    gr_r        <= gr_nxt;
    ri_r        <= ri_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_r       <= hit_nxt;
    prev_r      <= prev_nxt;
    j_r         <= j_nxt;
    rm_n_r      <= rm_n_nxt;
    tot_r       <= tot_nxt;
    big_r       <= big_nxt;
    used_r      <= used_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE) && !init_pend_r && !cfg_we;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // The table never holds more segments than the limit allows.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    !init_pend_r |-> (CMP_W'(cnt_r) <= CMP_W'(lim_r)))
    else $error("segment count above limit");

  // Table writes stay inside the used part of the table or one slot beyond.
  a_waddr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CMP_W'(mem_waddr) <= CMP_W'(cnt_r)))
    else $error("table write outside the segment range");

  // One request at a time: an accepted word closes the input.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("request taken while busy");

endmodule

`default_nettype wire

### rtl/core/ffsa_mem.sv
// ----------------------------------------------------------------------------
// ffsa_mem
// Segment table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ffsa_mem
  import ffsa_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_SEGMENTS,
  parameter int AW    = $clog2(DEF_MAX_SEGMENTS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire seg_t          wdata,
  input  wire logic [AW-1:0] raddr,
  output seg_t               rdata
);

  seg_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
